// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define EFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define EFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/efr_pkg.sv -----
// ----------------------------------------------------------------------------
// efr_pkg
// Types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

  localparam int MSG_SIZE = 64;

  localparam logic [7:0] END_MARK = 8'hC0;
  localparam logic [7:0] ESC_MARK = 8'hDB;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  localparam logic [7:0] LEN_MIN = 8'd2;
  localparam logic [7:0] LEN_MAX = 8'(MSG_SIZE + 2);

  localparam logic [6:0] POS_ADDR    = 7'd0;
  localparam logic [6:0] POS_LEN     = 7'd1;
  localparam logic [6:0] POS_TYPE    = 7'd2;
  localparam logic [6:0] PAYLOAD_OFS = 7'd3;
  localparam logic [6:0] EXP_RESET   = 7'd2;

  typedef enum logic [2:0] {
    K_ADDR    = 3'd0,
    K_LEN     = 3'd1,
    K_TYPE    = 3'd2,
    K_PAYLOAD = 3'd3,
    K_GOOD    = 3'd4,
    K_BAD     = 3'd5,
    K_DROPPED = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       store_ready;
    logic       queue_full;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [5:0] payload_index;
  } result_t;

  typedef struct packed {
    logic [6:0] position;
    logic [6:0] expected_count;
    logic       escape_pending;
    logic       frame_error;
    logic       frame_started;
  } frame_state_t;

  localparam frame_state_t STATE_RESET = '{
    position:       7'd0,
    expected_count: EXP_RESET,
    escape_pending: 1'b0,
    frame_error:    1'b0,
    frame_started:  1'b0
  };

endpackage

`default_nettype wire

// ----- src/escaped_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// SLIP-style deframer: one raw byte in, at most one decoded result out.
// ----------------------------------------------------------------------------
// Channel   Signals                            Moves
// item      item_valid, item_ready, item       one raw byte per transaction
// result    result_valid, result_ready, result one decoded byte or frame status
//
// One byte per cycle unless result stalls; each byte is decoded in the cycle it
// is accepted and any result shows in the output register on the next cycle.
// item_ready is high while the output register is empty or being drained.
// A stall on result holds the output register and blocks item intake only.
// Reset (rst, synchronous) clears the frame state and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module escaped_frame_receiver (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  efr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output efr_pkg::result_t result
);
  import efr_pkg::*;

  frame_state_t st;
  frame_state_t st_next;
  logic         emit;
  result_t      res;
  logic         accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  efr_decode u_decode (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= STATE_RESET;
      result_valid <= 1'b0;
    end else if (accept) begin
      st           <= st_next;
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= res;
    end
  end

  `EFR_ASSERT(a_pos_bound, st.position <= st.expected_count, "position past expected count")
  `EFR_ASSERT(a_exp_range, st.expected_count >= EXP_RESET && st.expected_count <= 7'(MSG_SIZE + 3), "expected count out of range")
  `EFR_ASSERT(a_end_clears, accept && item.rx_byte == END_MARK |=> st.position == 7'd0 && !st.frame_started && !st.frame_error, "frame state not cleared at end mark")
  `EFR_ASSERT_ALWAYS(a_rst_empty, rst |=> !result_valid && item_ready, "output not empty after reset")

endmodule

`default_nettype wire

// ----- src/efr_decode.sv -----
// ----------------------------------------------------------------------------
// efr_decode
// Per-byte deframing step: next frame state and the optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_decode (
  input  efr_pkg::frame_state_t st,
  input  efr_pkg::item_t        item,
  output efr_pkg::frame_state_t st_next,
  output logic                  emit,
  output efr_pkg::result_t      res
);
  import efr_pkg::*;

  logic [7:0] data;
  logic [6:0] pay_idx;

  assign data    = st.escape_pending ? (item.rx_byte ^ ESC_XOR) : item.rx_byte;
  assign pay_idx = st.position - PAYLOAD_OFS;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '{kind: K_ADDR, value: 8'd0, payload_index: 6'd0};

    if (item.rx_byte == END_MARK) begin
      if (st.frame_started) begin
        emit = 1'b1;
        if (!st.frame_error && st.position == st.expected_count) begin
          res.kind = item.queue_full ? K_DROPPED : K_GOOD;
        end else begin
          res.kind = K_BAD;
        end
      end
      st_next = STATE_RESET;
    end else begin
      st_next.frame_started = 1'b1;
      if (!st.frame_error) begin
        if (st.position >= st.expected_count) begin
          st_next.frame_error = 1'b1;
        end else if (item.rx_byte == ESC_MARK) begin
          if (st.escape_pending) begin
            st_next.frame_error = 1'b1;
          end else begin
            st_next.escape_pending = 1'b1;
          end
        end else begin
          st_next.escape_pending = 1'b0;
          res.value = data;
          case (st.position)
            POS_ADDR: begin
              if (!item.store_ready) begin
                st_next.frame_error = 1'b1;
              end else begin
                emit     = 1'b1;
                res.kind = K_ADDR;
              end
            end
            POS_LEN: begin
              if (data < LEN_MIN || data > LEN_MAX) begin
                st_next.frame_error = 1'b1;
              end else begin
                emit                   = 1'b1;
                res.kind               = K_LEN;
                st_next.expected_count = data[6:0] + 7'd1;
              end
            end
            POS_TYPE: begin
              emit     = 1'b1;
              res.kind = K_TYPE;
            end
            default: begin
              emit              = 1'b1;
              res.kind          = K_PAYLOAD;
              res.payload_index = pay_idx[5:0];
            end
          endcase
          if (emit) begin
            st_next.position = st.position + 7'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
